>>> rtl/core/ecpa_pkg.sv
// Shared types, field arithmetic and the sequencer program for the binary curve point adder.
// No dependencies; used by every module of the block by scoped names.
package ecpa_pkg;

  localparam int FieldW = 79;
  localparam int LoW = 64;
  localparam int HiW = 15;
  localparam int PolyMid = 9;
  localparam logic [FieldW-1:0] FieldPoly = 79'h201;
  localparam int QDepth = 2;
  localparam int PcW = 6;
  localparam int RegAw = 4;

  typedef logic [FieldW-1:0] fe_t;

  typedef enum logic [2:0] {
    UopAdd,
    UopMul,
    UopSqrn,
    UopCmp,
    UopJmp,
    UopEnd,
    UopOut
  } uop_e;

  typedef struct packed {
    uop_e             op;
    logic [RegAw-1:0] dst;
    logic [RegAw-1:0] sa;
    logic [RegAw-1:0] sb;
    logic [PcW-1:0]   arg;
  } uop_t;

  typedef struct packed {
    fe_t  x0;
    fe_t  y0;
    logic inf0;
    fe_t  x1;
    fe_t  y1;
    logic inf1;
    logic x_eq;
    logic y_eq;
    logic x1_zero;
  } item_t;

  typedef struct packed {
    logic       start;
    logic       sqr;
    logic [5:0] cnt;
  } falu_req_t;

  // register file map
  localparam logic [RegAw-1:0] RegX0 = 4'd0;
  localparam logic [RegAw-1:0] RegY0 = 4'd1;
  localparam logic [RegAw-1:0] RegX1 = 4'd2;
  localparam logic [RegAw-1:0] RegY1 = 4'd3;
  localparam logic [RegAw-1:0] RegA  = 4'd4;
  localparam logic [RegAw-1:0] RegB  = 4'd5;
  localparam logic [RegAw-1:0] RegT0 = 4'd6;
  localparam logic [RegAw-1:0] RegT1 = 4'd7;
  localparam logic [RegAw-1:0] RegT2 = 4'd8;
  localparam logic [RegAw-1:0] RegT3 = 4'd9;
  localparam logic [RegAw-1:0] RegD  = 4'd10;
  localparam logic [RegAw-1:0] RegN  = 4'd11;
  localparam logic [RegAw-1:0] RegE  = 4'd12;
  localparam logic [RegAw-1:0] RegS  = 4'd13;
  localparam logic [RegAw-1:0] RegW  = 4'd14;
  localparam logic [RegAw-1:0] RegP  = 4'd15;

  localparam logic [PcW-1:0] PcCheck   = 6'd0;
  localparam logic [PcW-1:0] PcGeneral = 6'd19;
  localparam logic [PcW-1:0] PcCommon  = 6'd23;
  localparam logic [PcW-1:0] PcDouble  = 6'd53;

  // multiply by x and reduce
  function automatic fe_t fe_mulx(fe_t p);
    fe_t r;
    r = {p[FieldW-2:0], 1'b0};
    if (p[FieldW-1]) r = r ^ FieldPoly;
    return r;
  endfunction

  function automatic fe_t fe_sqr(fe_t p);
    logic [2*FieldW-2:0] t;
    t = '0;
    for (int i = 0; i < FieldW; i++) t[2*i] = p[i];
    for (int i = 2*FieldW-2; i >= FieldW; i--) begin
      t[i-FieldW]         = t[i-FieldW] ^ t[i];
      t[i-FieldW+PolyMid] = t[i-FieldW+PolyMid] ^ t[i];
    end
    return t[FieldW-1:0];
  endfunction

  function automatic uop_t mk(uop_e op, logic [RegAw-1:0] dst, logic [RegAw-1:0] sa,
                              logic [RegAw-1:0] sb, logic [PcW-1:0] arg);
    uop_t u;
    u.op = op;
    u.dst = dst;
    u.sa = sa;
    u.sb = sb;
    u.arg = arg;
    return u;
  endfunction

  // Sequencer program: curve checks, general and doubling set-up, shared inversion tail.
  function automatic uop_t uop_rom(logic [PcW-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(UopSqrn, RegT0, RegY0, RegY0, 6'd1);
      6'd1:  u = mk(UopMul,  RegT1, RegX0, RegY0, 6'd0);
      6'd2:  u = mk(UopAdd,  RegT0, RegT0, RegT1, 6'd0);
      6'd3:  u = mk(UopSqrn, RegT1, RegX0, RegX0, 6'd1);
      6'd4:  u = mk(UopMul,  RegT2, RegT1, RegX0, 6'd0);
      6'd5:  u = mk(UopMul,  RegT3, RegT1, RegA,  6'd0);
      6'd6:  u = mk(UopAdd,  RegT2, RegT2, RegT3, 6'd0);
      6'd7:  u = mk(UopAdd,  RegT2, RegT2, RegB,  6'd0);
      6'd8:  u = mk(UopCmp,  RegT0, RegT0, RegT2, 6'd0);
      6'd9:  u = mk(UopSqrn, RegT0, RegY1, RegY1, 6'd1);
      6'd10: u = mk(UopMul,  RegT1, RegX1, RegY1, 6'd0);
      6'd11: u = mk(UopAdd,  RegT0, RegT0, RegT1, 6'd0);
      6'd12: u = mk(UopSqrn, RegT1, RegX1, RegX1, 6'd1);
      6'd13: u = mk(UopMul,  RegT2, RegT1, RegX1, 6'd0);
      6'd14: u = mk(UopMul,  RegT3, RegT1, RegA,  6'd0);
      6'd15: u = mk(UopAdd,  RegT2, RegT2, RegT3, 6'd0);
      6'd16: u = mk(UopAdd,  RegT2, RegT2, RegB,  6'd0);
      6'd17: u = mk(UopCmp,  RegT0, RegT0, RegT2, 6'd1);
      6'd18: u = mk(UopEnd,  RegT0, RegT0, RegT0, 6'd0);
      // distinct x: lambda = (y0+y1)/(x0+x1), rx picks up x0+x1
      6'd19: u = mk(UopAdd,  RegD,  RegX0, RegX1, 6'd0);
      6'd20: u = mk(UopAdd,  RegN,  RegY0, RegY1, 6'd0);
      6'd21: u = mk(UopAdd,  RegE,  RegX0, RegX0, 6'd0);
      6'd22: u = mk(UopAdd,  RegS,  RegD,  RegE,  6'd0);
      // Itoh-Tsujii inversion of D into P
      6'd23: u = mk(UopSqrn, RegW,  RegD,  RegD,  6'd1);
      6'd24: u = mk(UopMul,  RegT0, RegD,  RegW,  6'd0);
      6'd25: u = mk(UopSqrn, RegW,  RegT0, RegT0, 6'd2);
      6'd26: u = mk(UopMul,  RegT1, RegT0, RegW,  6'd0);
      6'd27: u = mk(UopSqrn, RegW,  RegT1, RegT1, 6'd4);
      6'd28: u = mk(UopMul,  RegT2, RegT1, RegW,  6'd0);
      6'd29: u = mk(UopSqrn, RegW,  RegT2, RegT2, 6'd8);
      6'd30: u = mk(UopMul,  RegT3, RegT2, RegW,  6'd0);
      6'd31: u = mk(UopSqrn, RegW,  RegT3, RegT3, 6'd16);
      6'd32: u = mk(UopMul,  RegP,  RegT3, RegW,  6'd0);
      6'd33: u = mk(UopSqrn, RegW,  RegP,  RegP,  6'd32);
      6'd34: u = mk(UopMul,  RegP,  RegP,  RegW,  6'd0);
      6'd35: u = mk(UopSqrn, RegW,  RegP,  RegP,  6'd8);
      6'd36: u = mk(UopMul,  RegP,  RegT2, RegW,  6'd0);
      6'd37: u = mk(UopSqrn, RegW,  RegP,  RegP,  6'd4);
      6'd38: u = mk(UopMul,  RegP,  RegT1, RegW,  6'd0);
      6'd39: u = mk(UopSqrn, RegW,  RegP,  RegP,  6'd2);
      6'd40: u = mk(UopMul,  RegP,  RegT0, RegW,  6'd0);
      6'd41: u = mk(UopSqrn, RegP,  RegP,  RegP,  6'd1);
      // lambda, rx, ry
      6'd42: u = mk(UopMul,  RegT0, RegN,  RegP,  6'd0);
      6'd43: u = mk(UopAdd,  RegT0, RegT0, RegE,  6'd0);
      6'd44: u = mk(UopSqrn, RegW,  RegT0, RegT0, 6'd1);
      6'd45: u = mk(UopAdd,  RegT1, RegA,  RegW,  6'd0);
      6'd46: u = mk(UopAdd,  RegT1, RegT1, RegT0, 6'd0);
      6'd47: u = mk(UopAdd,  RegT1, RegT1, RegS,  6'd0);
      6'd48: u = mk(UopAdd,  RegW,  RegX1, RegT1, 6'd0);
      6'd49: u = mk(UopMul,  RegW,  RegW,  RegT0, 6'd0);
      6'd50: u = mk(UopAdd,  RegW,  RegW,  RegT1, 6'd0);
      6'd51: u = mk(UopAdd,  RegW,  RegW,  RegY1, 6'd0);
      6'd52: u = mk(UopOut,  RegT1, RegT1, RegW,  6'd0);
      // doubling: lambda = x1 + y1/x1
      6'd53: u = mk(UopAdd,  RegE,  RegX0, RegX0, 6'd0);
      6'd54: u = mk(UopAdd,  RegS,  RegX0, RegX0, 6'd0);
      6'd55: u = mk(UopAdd,  RegD,  RegX1, RegE,  6'd0);
      6'd56: u = mk(UopAdd,  RegN,  RegY1, RegE,  6'd0);
      6'd57: u = mk(UopAdd,  RegE,  RegX1, RegS,  6'd0);
      6'd58: u = mk(UopJmp,  RegT0, RegT0, RegT0, PcCommon);
      default: u = mk(UopEnd, RegT0, RegT0, RegT0, 6'd0);
    endcase
    return u;
  endfunction

endpackage

>>> rtl/core/ecpa_front.sv
// Input stage: registers one point pair and classifies it (equal x, equal y, zero x).
// Depends on ecpa_pkg.
module ecpa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ecpa_pkg::fe_t      x0_i,
  input  ecpa_pkg::fe_t      y0_i,
  input  logic               inf0_i,
  input  ecpa_pkg::fe_t      x1_i,
  input  ecpa_pkg::fe_t      y1_i,
  input  logic               inf1_i,
  output logic               q_push_o,
  output ecpa_pkg::item_t    q_item_o,
  input  logic               q_full_i
);

  logic            valid_q, valid_d;
  ecpa_pkg::item_t item_q;
  logic            accept;

  assign full     = valid_q && q_full_i;
  assign accept   = push && !full;
  assign q_push_o = valid_q && !q_full_i;
  assign q_item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) valid_d = 1'b1;
    else if (q_push_o) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.x0      <= x0_i;
      item_q.y0      <= y0_i;
      item_q.inf0    <= inf0_i;
      item_q.x1      <= x1_i;
      item_q.y1      <= y1_i;
      item_q.inf1    <= inf1_i;
      item_q.x_eq    <= (x0_i == x1_i);
      item_q.y_eq    <= (y0_i == y1_i);
      item_q.x1_zero <= (x1_i == '0);
    end
  end

endmodule

>>> rtl/core/ecpa_fifo.sv
// Short queue of classified items between the front and back parts.
// Depends on ecpa_pkg.
module ecpa_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ecpa_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output ecpa_pkg::item_t data_o,
  output logic            empty_o
);

  localparam int PtrW = (ecpa_pkg::QDepth > 1) ? $clog2(ecpa_pkg::QDepth) : 1;
  localparam int CntW = $clog2(ecpa_pkg::QDepth + 1);

  ecpa_pkg::item_t mem_q [ecpa_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(ecpa_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] nxt(logic [PtrW-1:0] p);
    return (p == PtrW'(ecpa_pkg::QDepth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= nxt(wr_q);
      if (do_pop) rd_q <= nxt(rd_q);
      if (do_push && !do_pop) cnt_q <= CntW'(cnt_q + 1'b1);
      else if (do_pop && !do_push) cnt_q <= CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

>>> rtl/core/ecpa_falu.sv
// Field unit: digit-serial GF(2^79) multiplier and repeated squarer.
// Depends on ecpa_pkg.
module ecpa_falu #(
  parameter int DIGIT_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ecpa_pkg::falu_req_t req_i,
  input  ecpa_pkg::fe_t       a_i,
  input  ecpa_pkg::fe_t       b_i,
  output logic                done_o,
  output ecpa_pkg::fe_t       res_o
);

  localparam int NDig = (ecpa_pkg::FieldW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PadW = NDig * DIGIT_BITS;
  localparam int CntMax = (NDig > 32) ? NDig : 32;
  localparam int CntW = $clog2(CntMax + 1);

  logic                busy_q;
  logic                sqr_q;
  logic [CntW-1:0]     cnt_q;
  ecpa_pkg::fe_t       acc_q, a_q, step;
  logic [PadW-1:0]     bq_q;

  assign done_o = busy_q && (cnt_q == '0);
  assign res_o  = acc_q;

  // one digit of the multiplier, top first
  always_comb begin
    step = acc_q;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      step = ecpa_pkg::fe_mulx(step);
      if (bq_q[PadW-1-k]) step = step ^ a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.sqr ? CntW'(req_i.cnt) : CntW'(NDig);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqr_q <= req_i.sqr;
      a_q   <= a_i;
      acc_q <= req_i.sqr ? a_i : '0;
      bq_q  <= PadW'(b_i);
    end else if (busy_q && cnt_q != '0) begin
      if (sqr_q) begin
        acc_q <= ecpa_pkg::fe_sqr(acc_q);
      end else begin
        acc_q <= step;
        bq_q  <= bq_q << DIGIT_BITS;
      end
    end
  end

endmodule

>>> rtl/core/ecpa_back.sv
// Back part: sequencer over the program in ecpa_pkg, register file memory, result register.
// Depends on ecpa_pkg and ecpa_falu.
module ecpa_back #(
  parameter int DIGIT_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ecpa_pkg::fe_t   curve_a_i,
  input  ecpa_pkg::fe_t   curve_b_i,
  input  logic            q_empty_i,
  input  ecpa_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  input  logic            res_pop_i,
  output ecpa_pkg::fe_t   res_x_o,
  output ecpa_pkg::fe_t   res_y_o,
  output logic            res_inf_o,
  output logic            res_err_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SLoad  = 3'd1;
  localparam logic [2:0] SFetch = 3'd2;
  localparam logic [2:0] SExec  = 3'd3;
  localparam logic [2:0] SWait  = 3'd4;
  localparam logic [2:0] SEmit  = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [ecpa_pkg::PcW-1:0]      pc_q, pc_d;
  logic [2:0]                    ld_q, ld_d;
  logic [1:0]                    flags_q, flags_d;
  ecpa_pkg::item_t               cur_q;
  ecpa_pkg::uop_t                uop;
  ecpa_pkg::fe_t                 rf_q [16];
  ecpa_pkg::fe_t                 rda_q, rdb_q, wdata;
  logic [ecpa_pkg::RegAw-1:0]    waddr;
  logic                          we;
  ecpa_pkg::falu_req_t           falu_req;
  logic                          falu_done;
  ecpa_pkg::fe_t                 falu_res;
  ecpa_pkg::fe_t                 pend_x_q, pend_y_q, pend_x_d, pend_y_d;
  logic                          pend_inf_q, pend_err_q, pend_inf_d, pend_err_d;
  logic                          out_valid_q, out_load;
  ecpa_pkg::fe_t                 out_x_q, out_y_q;
  logic                          out_inf_q, out_err_q;
  logic                          ok0, ok1;

  assign uop = ecpa_pkg::uop_rom(pc_q);
  assign ok0 = flags_q[0] || cur_q.inf0;
  assign ok1 = flags_q[1] || cur_q.inf1;

  ecpa_falu #(.DIGIT_BITS(DIGIT_BITS)) u_falu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (falu_req),
    .a_i   (rda_q),
    .b_i   (rdb_q),
    .done_o(falu_done),
    .res_o (falu_res)
  );

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    ld_d       = ld_q;
    flags_d    = flags_q;
    we         = 1'b0;
    waddr      = uop.dst;
    wdata      = falu_res;
    falu_req   = '0;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    pend_x_d   = pend_x_q;
    pend_y_d   = pend_y_q;
    pend_inf_d = pend_inf_q;
    pend_err_d = pend_err_q;
    unique case (state_q)
      SIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          ld_d    = '0;
          state_d = SLoad;
        end
      end
      SLoad: begin
        we    = 1'b1;
        waddr = ecpa_pkg::RegAw'(ld_q);
        unique case (ld_q)
          3'd0: wdata = cur_q.x0;
          3'd1: wdata = cur_q.y0;
          3'd2: wdata = cur_q.x1;
          3'd3: wdata = cur_q.y1;
          3'd4: wdata = curve_a_i;
          default: wdata = curve_b_i;
        endcase
        ld_d = 3'(ld_q + 1'b1);
        if (ld_q == 3'd5) begin
          pc_d    = ecpa_pkg::PcCheck;
          state_d = SFetch;
        end
      end
      SFetch: begin
        if (uop.op == ecpa_pkg::UopJmp) begin
          pc_d = uop.arg;
        end else if (uop.op == ecpa_pkg::UopEnd) begin
          // classify once both curve checks are known
          pend_x_d   = '0;
          pend_y_d   = '0;
          pend_inf_d = 1'b0;
          pend_err_d = 1'b0;
          state_d    = SEmit;
          priority if (!ok0 || !ok1) begin
            pend_err_d = 1'b1;
          end else if (cur_q.inf0 && cur_q.inf1) begin
            pend_inf_d = 1'b1;
          end else if (cur_q.inf0) begin
            pend_x_d = cur_q.x1;
            pend_y_d = cur_q.y1;
          end else if (cur_q.inf1) begin
            pend_x_d = cur_q.x0;
            pend_y_d = cur_q.y0;
          end else if (!cur_q.x_eq) begin
            pc_d    = ecpa_pkg::PcGeneral;
            state_d = SFetch;
          end else if (!cur_q.y_eq || cur_q.x1_zero) begin
            pend_inf_d = 1'b1;
          end else begin
            pc_d    = ecpa_pkg::PcDouble;
            state_d = SFetch;
          end
        end else begin
          state_d = SExec;
        end
      end
      SExec: begin
        unique case (uop.op)
          ecpa_pkg::UopAdd: begin
            we      = 1'b1;
            wdata   = rda_q ^ rdb_q;
            pc_d    = ecpa_pkg::PcW'(pc_q + 1'b1);
            state_d = SFetch;
          end
          ecpa_pkg::UopCmp: begin
            flags_d[uop.arg[0]] = (rda_q == rdb_q);
            pc_d    = ecpa_pkg::PcW'(pc_q + 1'b1);
            state_d = SFetch;
          end
          ecpa_pkg::UopMul, ecpa_pkg::UopSqrn: begin
            falu_req.start = 1'b1;
            falu_req.sqr   = (uop.op == ecpa_pkg::UopSqrn);
            falu_req.cnt   = uop.arg;
            state_d        = SWait;
          end
          ecpa_pkg::UopOut: begin
            pend_x_d   = rda_q;
            pend_y_d   = rdb_q;
            pend_inf_d = 1'b0;
            pend_err_d = 1'b0;
            state_d    = SEmit;
          end
          default: state_d = SFetch;
        endcase
      end
      SWait: begin
        if (falu_done) begin
          we      = 1'b1;
          pc_d    = ecpa_pkg::PcW'(pc_q + 1'b1);
          state_d = SFetch;
        end
      end
      SEmit: begin
        if (!out_valid_q || res_pop_i) begin
          out_load = 1'b1;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pc_q        <= '0;
      ld_q        <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ld_q    <= ld_d;
      flags_q <= flags_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_item_i;
    pend_x_q   <= pend_x_d;
    pend_y_q   <= pend_y_d;
    pend_inf_q <= pend_inf_d;
    pend_err_q <= pend_err_d;
    if (out_load) begin
      out_x_q   <= pend_x_q;
      out_y_q   <= pend_y_q;
      out_inf_q <= pend_inf_q;
      out_err_q <= pend_err_q;
    end
  end

  // register file: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (we) rf_q[waddr] <= wdata;
    rda_q <= rf_q[uop.sa];
    rdb_q <= rf_q[uop.sb];
  end

  assign res_valid_o = out_valid_q;
  assign res_x_o     = out_x_q;
  assign res_y_o     = out_y_q;
  assign res_inf_o   = out_inf_q;
  assign res_err_o   = out_err_q;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_x_q == '0 && out_y_q == '0 && !out_inf_q)
    else $error("error result carries coordinates");
  a_inf_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_inf_q |-> out_x_q == '0 && out_y_q == '0)
    else $error("infinite result carries coordinates");
  a_done_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    falu_done |-> state_q == SWait)
    else $error("field unit finished outside wait");
  a_start_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    falu_req.start |-> state_q == SExec && $past(state_q) == SFetch)
    else $error("field unit started without operand fetch");

endmodule

>>> rtl/core/binary_ec_point_add.sv
// Top level of the binary curve point adder: configuration port, front, queue and back.
// Depends on ecpa_pkg, ecpa_front, ecpa_fifo and ecpa_back.
//
// Adds two affine points on y^2 + xy = x^3 + a*x^2 + b over GF(2^79) reduced by
// x^79 + x^9 + 1. Both points are first checked against the curve; a failing point
// gives off_curve_error with zero coordinates. Points arrive on a push/full queue
// interface and sums leave on an empty/pop interface, one result per item in order.
// An input register and a two-entry queue let new items in while the back part is
// busy and while a finished sum waits to be popped. The back part runs a fixed
// program of field operations through a 16-entry register file and one field unit
// that multiplies DIGIT_BITS bits per cycle or squares once per cycle; inversion
// is Itoh-Tsujii. A general addition or doubling runs the inversion tail; points at
// infinity, inverse points and off-curve points finish after the two curve checks.
// Coefficients a and b sit at byte addresses 0, 8, 16 and 24 (a low, a high,
// b low, b high); write them only while the block is idle.
module binary_ec_point_add #(
  parameter int DIGIT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input points
  input  logic        push,
  output logic        full,
  input  logic [63:0] first_x_low_i,
  input  logic [14:0] first_x_high_i,
  input  logic [63:0] first_y_low_i,
  input  logic [14:0] first_y_high_i,
  input  logic        first_at_infinity_i,
  input  logic [63:0] second_x_low_i,
  input  logic [14:0] second_x_high_i,
  input  logic [63:0] second_y_low_i,
  input  logic [14:0] second_y_high_i,
  input  logic        second_at_infinity_i,
  // sums
  output logic        empty,
  input  logic        pop,
  output logic [63:0] sum_x_low_o,
  output logic [14:0] sum_x_high_o,
  output logic [63:0] sum_y_low_o,
  output logic [14:0] sum_y_high_o,
  output logic        sum_at_infinity_o,
  output logic        off_curve_error_o
);

  localparam logic [1:0] CfgALo = 2'd0;
  localparam logic [1:0] CfgAHi = 2'd1;
  localparam logic [1:0] CfgBLo = 2'd2;
  localparam logic [1:0] CfgBHi = 2'd3;

  logic [63:0]     a_lo_q, b_lo_q;
  logic [14:0]     a_hi_q, b_hi_q;
  logic            cfg_wr;
  ecpa_pkg::fe_t   curve_a, curve_b, res_x, res_y;
  logic            q_push, q_full, q_pop, q_empty, res_valid;
  ecpa_pkg::item_t q_in, q_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign curve_a = {a_hi_q, a_lo_q};
  assign curve_b = {b_hi_q, b_lo_q};

  // register index is the 8-byte slot; byte offset bits are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_lo_q <= '0;
      a_hi_q <= '0;
      b_lo_q <= '0;
      b_hi_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        CfgALo: a_lo_q <= pwdata;
        CfgAHi: a_hi_q <= pwdata[14:0];
        CfgBLo: b_lo_q <= pwdata;
        CfgBHi: b_hi_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      CfgALo: prdata = a_lo_q;
      CfgAHi: prdata = {49'd0, a_hi_q};
      CfgBLo: prdata = b_lo_q;
      CfgBHi: prdata = {49'd0, b_hi_q};
      default: prdata = '0;
    endcase
  end

  // front: take and classify
  ecpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .x0_i    ({first_x_high_i, first_x_low_i}),
    .y0_i    ({first_y_high_i, first_y_low_i}),
    .inf0_i  (first_at_infinity_i),
    .x1_i    ({second_x_high_i, second_x_low_i}),
    .y1_i    ({second_y_high_i, second_y_low_i}),
    .inf1_i  (second_at_infinity_i),
    .q_push_o(q_push),
    .q_item_o(q_in),
    .q_full_i(q_full)
  );

  // decouple front from back
  ecpa_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  // back: curve checks, case selection, field program, result register
  ecpa_back #(.DIGIT_BITS(DIGIT_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .curve_a_i  (curve_a),
    .curve_b_i  (curve_b),
    .q_empty_i  (q_empty),
    .q_item_i   (q_out),
    .q_pop_o    (q_pop),
    .res_valid_o(res_valid),
    .res_pop_i  (pop),
    .res_x_o    (res_x),
    .res_y_o    (res_y),
    .res_inf_o  (sum_at_infinity_o),
    .res_err_o  (off_curve_error_o)
  );

  assign empty        = !res_valid;
  assign sum_x_low_o  = res_x[63:0];
  assign sum_x_high_o = res_x[78:64];
  assign sum_y_low_o  = res_y[63:0];
  assign sum_y_high_o = res_y[78:64];

endmodule
